// ===== rtl/ctc_pkg.sv =====
package ctc_pkg;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_TICK       = 2'd1,
        OP_TRIGGER    = 2'd2,
        OP_HARD_RESET = 2'd3
    } op_t;

    // control word bit positions
    localparam int CW_INT_EN  = 7;
    localparam int CW_COUNTER = 6;
    localparam int CW_PRE256  = 5;
    localparam int CW_RISING  = 4;
    localparam int CW_TRIGGER = 3;
    localparam int CW_CONST   = 2;
    localparam int CW_SWRESET = 1;
    localparam int CW_VECTOR  = 0;

    localparam int CNT_W = 9;
    localparam int MASK_W = 4;

    localparam logic [CNT_W-1:0] PRESCALE_16  = 9'd16;
    localparam logic [CNT_W-1:0] PRESCALE_256 = 9'd256;
    localparam logic [CNT_W-1:0] CONST_OF_ZERO = 9'd256;

    typedef struct packed {
        logic       write;
        logic       trigger;
        logic       tick;
        logic       hard_reset;
        logic [7:0] data;
        logic       up;
    } chan_cmd_t;

    typedef struct packed {
        logic zero;
        logic irq;
        logic awaiting;
    } chan_stat_t;

endpackage

// ===== rtl/ctc_channel.sv =====
module ctc_channel (
    input  logic                clk,
    input  logic                rst_n,
    input  ctc_pkg::chan_cmd_t  cmd,
    output ctc_pkg::chan_stat_t stat
);
    import ctc_pkg::*;

    logic [7:0]       cw_reg, cw_next;
    logic [CNT_W-1:0] tc_reg, tc_next;
    logic [CNT_W-1:0] down_reg, down_next;
    logic [CNT_W-1:0] pre_reg, pre_next;
    logic             await_reg, await_next;
    logic             counting_reg, counting_next;
    logic             enabled_reg, enabled_next;
    logic             reload_reg, reload_next;
    logic             edge_reg, edge_next;
    logic [CNT_W-1:0] pre_start;
    logic [CNT_W-1:0] pre_dec;
    logic             zero;
    logic             write_counts;

    assign pre_start = cw_reg[CW_PRE256] ? PRESCALE_256 : PRESCALE_16;
    assign pre_dec   = pre_reg - 9'd1;
    assign write_counts = !cw_reg[CW_TRIGGER];

    always_comb
    begin
        cw_next       = cw_reg;
        tc_next       = tc_reg;
        down_next     = down_reg;
        pre_next      = pre_reg;
        await_next    = await_reg;
        counting_next = counting_reg;
        enabled_next  = enabled_reg;
        reload_next   = reload_reg;
        edge_next     = edge_reg;
        zero          = 1'b0;

        if (cmd.write)
        begin
            enabled_next = 1'b1;
            if (await_reg)
            begin
                tc_next       = (cmd.data == 8'd0) ? CONST_OF_ZERO : {1'b0, cmd.data};
                await_next    = 1'b0;
                counting_next = write_counts;
                if (write_counts)
                begin
                    pre_next    = pre_start;
                    reload_next = 1'b1;
                end
            end
            else
            begin
                cw_next    = cmd.data;
                await_next = cmd.data[CW_CONST];
                if (cmd.data[CW_SWRESET])
                    counting_next = 1'b0;
            end
        end
        else if (cmd.trigger)
        begin
            if (cw_reg[CW_RISING] == cmd.up)
                edge_next = 1'b1;
            if (!counting_reg)
            begin
                pre_next      = pre_start;
                counting_next = 1'b1;
                reload_next   = 1'b1;
            end
        end
        else if (cmd.tick)
        begin
            if (counting_reg && !await_reg && enabled_reg)
            begin
                if (reload_reg)
                begin
                    down_next   = tc_reg;
                    reload_next = 1'b0;
                end
                else if (cw_reg[CW_COUNTER])
                begin
                    if (edge_reg)
                    begin
                        edge_next = 1'b0;
                        down_next = down_reg - 9'd1;
                    end
                end
                else
                begin
                    pre_next = pre_dec;
                    if (pre_dec == '0)
                    begin
                        pre_next  = pre_start;
                        down_next = down_reg - 9'd1;
                    end
                end
                if (down_next == '0)
                begin
                    reload_next = 1'b1;
                    zero        = 1'b1;
                end
            end
        end
        else if (cmd.hard_reset)
        begin
            await_next          = 1'b0;
            down_next           = '0;
            cw_next[CW_INT_EN]  = 1'b0;
            enabled_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg       <= '0;
            tc_reg       <= '0;
            down_reg     <= '0;
            pre_reg      <= '0;
            await_reg    <= 1'b0;
            counting_reg <= 1'b0;
            enabled_reg  <= 1'b0;
            reload_reg   <= 1'b0;
            edge_reg     <= 1'b0;
        end
        else
        begin
            cw_reg       <= cw_next;
            tc_reg       <= tc_next;
            down_reg     <= down_next;
            pre_reg      <= pre_next;
            await_reg    <= await_next;
            counting_reg <= counting_next;
            enabled_reg  <= enabled_next;
            reload_reg   <= reload_next;
            edge_reg     <= edge_next;
        end
    end

    assign stat.zero     = zero;
    assign stat.irq      = zero && cw_reg[CW_INT_EN];
    assign stat.awaiting = await_reg;

endmodule

// ===== rtl/four_channel_counter_timer_unit.sv =====
// Results: a word passes the input register and then, when the output is free, the result register.
// Throughput: one word per cycle while the output is not stalled; the input
// register feeds the channel update and the result register in the same cycle.
// Reset (rst_n low, asynchronous): all channel state, the vector and both
// pipeline registers clear; the block is ready right after reset.
module four_channel_counter_timer_unit #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [1:0]                 channel,
    input  logic [7:0]                 data,
    input  logic                       trg_high,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ctc_pkg::MASK_W-1:0] zero_count_mask,
    output logic [ctc_pkg::MASK_W-1:0] interrupt_mask
);
    import ctc_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        op_reg;
    logic [1:0]        channel_reg;
    logic [7:0]        data_reg;
    logic              trg_high_reg;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] zero_mask_reg;
    logic [MASK_W-1:0] int_mask_reg;
    logic [7:0]        vector_reg;

    logic              advance;
    logic              take;
    logic              is_vector;
    logic [MASK_W-1:0] zero_mask;
    logic [MASK_W-1:0] int_mask;

    chan_cmd_t  cmd  [NUM_CHANNELS];
    chan_stat_t stat [NUM_CHANNELS];

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign take     = in_valid && in_ready;

    // vector write: channel 0, bit 0 clear, no constant pending on channel 0
    assign is_vector = (op_reg == OP_WRITE) && (channel_reg == 2'd0)
                       && !data_reg[CW_VECTOR] && !stat[0].awaiting;

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        always_comb
        begin
            cmd[i].write      = advance && (op_reg == OP_WRITE) && !is_vector
                                && (32'(channel_reg) == i);
            cmd[i].trigger    = advance && (op_reg == OP_TRIGGER)
                                && (32'(channel_reg) == i);
            cmd[i].tick       = advance && (op_reg == OP_TICK);
            cmd[i].hard_reset = advance && (op_reg == OP_HARD_RESET);
            cmd[i].data       = data_reg;
            cmd[i].up         = trg_high_reg;
        end

        ctc_channel u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd[i]),
            .stat  (stat[i])
        );
    end

    // only the first four channels reach the masks
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < NUM_CHANNELS)
        begin : g_on
            assign zero_mask[m] = stat[m].zero;
            assign int_mask[m]  = stat[m].irq;
        end
        else
        begin : g_off
            assign zero_mask[m] = 1'b0;
            assign int_mask[m]  = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            op_reg        <= '0;
            channel_reg   <= '0;
            data_reg      <= '0;
            trg_high_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            zero_mask_reg <= '0;
            int_mask_reg  <= '0;
            vector_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                op_reg       <= op;
                channel_reg  <= channel;
                data_reg     <= data;
                trg_high_reg <= trg_high;
            end
            if (advance)
            begin
                zero_mask_reg <= zero_mask;
                int_mask_reg  <= int_mask;
                if (is_vector)
                    vector_reg <= data_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign zero_count_mask = zero_mask_reg;
    assign interrupt_mask  = int_mask_reg;

    a_irq_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((interrupt_mask & ~zero_count_mask) == '0))
        else $error("interrupt bit without zero count");

    a_non_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg != OP_TICK)) |=>
            (zero_count_mask == '0) && (interrupt_mask == '0))
        else $error("masks set by a word that is not a tick");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed word lost");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty input stage not ready");

    a_vector_ch0: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_vector) |-> (cmd[0].write == 1'b0))
        else $error("vector write reached channel 0");

endmodule
